@@ design/qau_pkg.sv @@
package qau_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 28;
  localparam int ProdWidth = 2 * DataWidth;
  // sum of four products plus sign and carry margin
  localparam int AccWidth  = ProdWidth + 4;
  // normalize: squared sum shifted by 2*FracBits
  localparam int NormWidth = ProdWidth + 2 + 2 * FracBits;
  localparam int RootWidth = NormWidth / 2;
  // dividend of normalize: magnitude << (2*FracBits+1) plus root
  localparam int DivWidth  = DataWidth + 2 * FracBits + 2;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SCALE = 3'd2,
    OP_NORM  = 3'd3,
    OP_MAT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DataWidth-1:0]  a_s;
    logic signed [DataWidth-1:0]  a_x;
    logic signed [DataWidth-1:0]  a_y;
    logic signed [DataWidth-1:0]  a_z;
    logic signed [DataWidth-1:0]  b_s;
    logic signed [DataWidth-1:0]  b_x;
    logic signed [DataWidth-1:0]  b_y;
    logic signed [DataWidth-1:0]  b_z;
    logic signed [DataWidth-1:0]  k;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] c0;
    logic signed [DataWidth-1:0] c1;
    logic signed [DataWidth-1:0] c2;
    logic signed [DataWidth-1:0] c3;
    logic [1:0]                  row;
    logic                        last;
    status_t                     status;
  } res_t;

  // round half up to FracBits when rnd is set, then saturate; sets sat on clamp
  function automatic logic signed [DataWidth-1:0] rnd_sat(
      input logic signed [AccWidth-1:0] v, input logic rnd, inout logic sat);
    logic signed [AccWidth-1:0] t;
    logic signed [AccWidth-1:0] mx;
    logic signed [AccWidth-1:0] mn;
    begin
      mx = AccWidth'({1'b0, {(DataWidth-1){1'b1}}});
      mn = -mx - AccWidth'(1);
      t = rnd ? ((v + (AccWidth'(1) <<< (FracBits - 1))) >>> FracBits) : v;
      if (t > mx) begin
        sat = 1'b1;
        rnd_sat = mx[DataWidth-1:0];
      end else if (t < mn) begin
        sat = 1'b1;
        rnd_sat = mn[DataWidth-1:0];
      end else begin
        rnd_sat = t[DataWidth-1:0];
      end
    end
  endfunction

endpackage

@@ design/qau_front.sv @@
module qau_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  qau_pkg::req_t   req_in,
  output logic            q_valid,
  output qau_pkg::req_t   q_data,
  input  logic            q_take
);

  qau_pkg::req_t                mem [qau_pkg::QueueDepth];
  logic [qau_pkg::QueueAw-1:0]  wr_ptr;
  logic [qau_pkg::QueueAw-1:0]  rd_ptr;
  logic [qau_pkg::QueueAw:0]    count;
  logic                         legal;
  logic                         wr_en;
  logic                         rd_en;

  // drop unknown opcodes at the door
  assign legal = (req_in.op == qau_pkg::OP_MUL) || (req_in.op == qau_pkg::OP_ADD) ||
                 (req_in.op == qau_pkg::OP_SCALE) || (req_in.op == qau_pkg::OP_NORM) ||
                 (req_in.op == qau_pkg::OP_MAT);
  assign full    = (count == (qau_pkg::QueueAw+1)'(qau_pkg::QueueDepth));
  assign wr_en   = push && !full && legal;
  assign q_valid = (count != '0);
  assign rd_en   = q_take && q_valid;
  assign q_data  = mem[rd_ptr];

  // store request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= req_in;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (qau_pkg::QueueAw+1)'(wr_en) - (qau_pkg::QueueAw+1)'(rd_en);
    end
  end

endmodule

@@ design/qau_norm.sv @@
module qau_norm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [qau_pkg::DataWidth-1:0] a0,
  input  logic signed [qau_pkg::DataWidth-1:0] a1,
  input  logic signed [qau_pkg::DataWidth-1:0] a2,
  input  logic signed [qau_pkg::DataWidth-1:0] a3,
  output logic                               busy,
  output logic                               done,
  output qau_pkg::res_t                      res
);

  localparam int NW = qau_pkg::NormWidth;
  localparam int RW = qau_pkg::RootWidth;
  localparam int DW = qau_pkg::DivWidth;
  localparam int W  = qau_pkg::DataWidth;
  localparam int SqW = 2 * W;
  localparam int CntW = $clog2(DW + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_DIVL = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } nstate_t;

  nstate_t                 state;
  logic signed [W-1:0]     av [4];
  logic [1:0]              idx;
  logic [SqW-1:0]          sq;
  logic [NW-1:0]           n2;
  logic [NW-1:0]           rem;
  logic [NW-1:0]           bitv;
  logic [NW-1:0]           root;
  logic [DW-1:0]           num;
  logic [DW-1:0]           quo;
  logic [DW:0]             drem;
  logic [CntW-1:0]         cnt;
  logic signed [W-1:0]     outv [4];
  logic                    zero;
  logic [W-1:0]            mag;
  logic [NW-1:0]           trial;
  logic [DW:0]             dshift;
  logic [DW:0]             den;
  logic                    sat;
  logic signed [qau_pkg::AccWidth-1:0] qs;
  logic signed [W-1:0]     qv;

  assign busy = (state != S_IDLE);
  assign mag  = av[idx][W-1] ? W'(-av[idx]) : av[idx];
  assign trial = root + bitv;
  assign den   = (DW+1)'(root) << 1;
  assign dshift = {drem[DW-1:0], num[DW-1]};

  // signed quotient, clamp to range
  always_comb begin
    sat = 1'b0;
    qs = av[idx][W-1] ? -qau_pkg::AccWidth'(quo) : qau_pkg::AccWidth'(quo);
    qv = qau_pkg::rnd_sat(qs, 1'b0, sat);
  end

  // sequence squares, root, then one division per part unless the norm is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            av[0] <= a0; av[1] <= a1; av[2] <= a2; av[3] <= a3;
            idx <= '0;
            n2  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq <= SqW'(mag) * SqW'(mag);
          state <= S_SUM;
        end
        S_SUM: begin
          n2 <= n2 + NW'(sq);
          if (idx == 2'd3) begin
            idx <= '0;
            state <= S_ROOT;
            bitv <= NW'(1) << (NW - 2);
            root <= '0;
            cnt  <= '0;
          end else begin
            idx <= idx + 1'b1;
            state <= S_SQ;
          end
        end
        S_ROOT: begin
          if (cnt == '0) begin
            rem <= n2 << (2 * qau_pkg::FracBits);
            zero <= (n2 == '0);
            cnt <= CntW'(1);
          end else if (bitv == '0) begin
            state <= zero ? S_OUT : S_DIVL;
          end else begin
            if (rem >= trial) begin
              rem  <= rem - trial;
              root <= (root >> 1) + bitv;
            end else begin
              root <= root >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        S_DIVL: begin
          num  <= (DW'(mag) << (2 * qau_pkg::FracBits + 1)) + DW'(root);
          drem <= '0;
          quo  <= '0;
          cnt  <= CntW'(DW);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            outv[idx] <= qv;
            if (idx == 2'd3) begin
              state <= S_OUT;
            end else begin
              idx <= idx + 1'b1;
              state <= S_DIVL;
            end
          end else begin
            num <= num << 1;
            if (dshift >= den) begin
              drem <= dshift - den;
              quo  <= {quo[DW-2:0], 1'b1};
            end else begin
              drem <= dshift;
              quo  <= {quo[DW-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // shape the result
  always_comb begin
    logic s1;
    logic signed [W-1:0] one;
    s1 = 1'b0;
    one = qau_pkg::rnd_sat(qau_pkg::AccWidth'(1) <<< qau_pkg::FracBits, 1'b0, s1);
    res.row  = 2'd0;
    res.last = 1'b1;
    if (zero) begin
      res.c0 = one;
      res.c1 = '0;
      res.c2 = '0;
      res.c3 = '0;
      res.status = qau_pkg::ST_ZERO;
    end else begin
      res.c0 = outv[0];
      res.c1 = outv[1];
      res.c2 = outv[2];
      res.c3 = outv[3];
      res.status = qau_pkg::ST_OK;
    end
  end

endmodule

@@ design/qau_back.sv @@
module qau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  qau_pkg::req_t  q_data,
  output logic           q_take,
  output logic           empty,
  input  logic           pop,
  output qau_pkg::res_t  res_out
);

  localparam int W  = qau_pkg::DataWidth;
  localparam int PW = qau_pkg::ProdWidth;
  localparam int AW = qau_pkg::AccWidth;

  // stage 1: products
  logic                  s1_v;
  qau_pkg::op_t          s1_op;
  logic signed [PW-1:0]  p [16];
  logic signed [W:0]     s1_sum [4];
  // stage 2: sums
  logic                  s2_v;
  qau_pkg::op_t          s2_op;
  logic signed [AW-1:0]  acc [9];
  // stage 3: result rows
  logic                  s3_v;
  qau_pkg::res_t         s3_res [3];
  logic [1:0]            s3_cnt;
  logic [1:0]            s3_row;
  qau_pkg::res_t         cur;
  logic                  s3_last_row;
  logic                  s3_fire;
  logic                  out_v;
  logic                  adv;
  logic                  is_norm;
  logic                  norm_start;
  logic                  norm_busy;
  logic                  norm_done;
  qau_pkg::res_t         norm_res;
  logic                  hold_norm;
  qau_pkg::res_t         res_next [3];
  logic [1:0]            cnt_next;

  qau_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .a0   (q_data.a_s),
    .a1   (q_data.a_x),
    .a2   (q_data.a_y),
    .a3   (q_data.a_z),
    .busy (norm_busy),
    .done (norm_done),
    .res  (norm_res)
  );

  assign empty   = !out_v;
  assign s3_last_row = (s3_row + 1'b1 == s3_cnt);
  assign s3_fire = s3_v && (!out_v || pop) && !hold_norm;
  // pipeline moves when stage 3 is free or retiring its last row
  assign adv     = !s3_v || (s3_fire && s3_last_row);
  assign is_norm = (q_data.op == qau_pkg::OP_NORM);
  // wait for an idle pipe and an empty output before a normalize, and for it to finish
  assign hold_norm = norm_busy || norm_done;
  assign norm_start = q_valid && is_norm && !norm_busy && !norm_done && !s1_v && !s2_v
                      && !s3_v && !out_v;
  assign q_take = (q_valid && !is_norm && adv && !hold_norm) || norm_start;

  // stage 1: form exact products and operand sums
  always_ff @(posedge clk) begin
    logic signed [W-1:0] a [4];
    logic signed [W-1:0] b [4];
    a[0] = q_data.a_s; a[1] = q_data.a_x; a[2] = q_data.a_y; a[3] = q_data.a_z;
    b[0] = q_data.b_s; b[1] = q_data.b_x; b[2] = q_data.b_y; b[3] = q_data.b_z;
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= q_valid && !is_norm && !hold_norm;
      s1_op <= q_data.op;
      for (int i = 0; i < 4; i++) begin
        s1_sum[i] <= (W+1)'(a[i]) + (W+1)'(b[i]);
      end
      unique case (q_data.op)
        qau_pkg::OP_MUL: begin
          for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
              p[4*i+j] <= PW'(a[i]) * PW'(b[j]);
            end
          end
        end
        qau_pkg::OP_SCALE: begin
          for (int i = 0; i < 4; i++) p[i] <= PW'(a[i]) * PW'(q_data.k);
          for (int i = 4; i < 16; i++) p[i] <= '0;
        end
        default: begin
          // matrix: xx yy zz xy xz yz sx sy sz
          p[0] <= PW'(a[1]) * PW'(a[1]);
          p[1] <= PW'(a[2]) * PW'(a[2]);
          p[2] <= PW'(a[3]) * PW'(a[3]);
          p[3] <= PW'(a[1]) * PW'(a[2]);
          p[4] <= PW'(a[1]) * PW'(a[3]);
          p[5] <= PW'(a[2]) * PW'(a[3]);
          p[6] <= PW'(a[0]) * PW'(a[1]);
          p[7] <= PW'(a[0]) * PW'(a[2]);
          p[8] <= PW'(a[0]) * PW'(a[3]);
          for (int i = 9; i < 16; i++) p[i] <= '0;
        end
      endcase
    end
  end

  // stage 2: exact sums
  always_ff @(posedge clk) begin
    logic signed [AW-1:0] e [16];
    logic signed [AW-1:0] one;
    logic signed [AW-1:0] nx [9];
    for (int i = 0; i < 16; i++) e[i] = AW'(p[i]);
    one = AW'(1) <<< (2 * qau_pkg::FracBits);
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v  <= s1_v;
      s2_op <= s1_op;
      for (int i = 0; i < 9; i++) nx[i] = '0;
      unique case (s1_op)
        qau_pkg::OP_MUL: begin
          nx[0] = e[0] - e[5] - e[10] - e[15];
          nx[1] = e[1] + e[4] + e[11] - e[14];
          nx[2] = e[2] + e[8] + e[13] - e[7];
          nx[3] = e[3] + e[12] + e[6] - e[9];
        end
        qau_pkg::OP_ADD: begin
          for (int i = 0; i < 4; i++) nx[i] = AW'(s1_sum[i]);
        end
        qau_pkg::OP_SCALE: begin
          for (int i = 0; i < 4; i++) nx[i] = e[i];
        end
        default: begin
          nx[0] = one - 2 * (e[1] + e[2]);
          nx[1] = 2 * (e[3] - e[8]);
          nx[2] = 2 * (e[4] + e[7]);
          nx[3] = 2 * (e[3] + e[8]);
          nx[4] = one - 2 * (e[0] + e[2]);
          nx[5] = 2 * (e[5] - e[6]);
          nx[6] = 2 * (e[4] - e[7]);
          nx[7] = 2 * (e[5] + e[6]);
          nx[8] = one - 2 * (e[0] + e[1]);
        end
      endcase
      acc <= nx;
    end
  end

  // stage 3 input: round (except for add) and saturate each row
  always_comb begin
    logic st;
    logic rnd;
    rnd = (s2_op != qau_pkg::OP_ADD);
    cnt_next = (s2_op == qau_pkg::OP_MAT) ? 2'd3 : 2'd1;
    for (int r = 0; r < 3; r++) begin
      st = 1'b0;
      res_next[r].c0 = qau_pkg::rnd_sat(acc[3*r], rnd, st);
      res_next[r].c1 = qau_pkg::rnd_sat(acc[3*r+1], rnd, st);
      res_next[r].c2 = qau_pkg::rnd_sat(acc[3*r+2], rnd, st);
      res_next[r].c3 = '0;
      if (s2_op != qau_pkg::OP_MAT && r == 0) begin
        res_next[r].c0 = '0;
        st = 1'b0;
        res_next[r].c0 = qau_pkg::rnd_sat(acc[0], rnd, st);
        res_next[r].c1 = qau_pkg::rnd_sat(acc[1], rnd, st);
        res_next[r].c2 = qau_pkg::rnd_sat(acc[2], rnd, st);
        res_next[r].c3 = qau_pkg::rnd_sat(acc[3], rnd, st);
      end
      res_next[r].row  = (s2_op == qau_pkg::OP_MAT) ? 2'(r) : 2'd0;
      res_next[r].last = (s2_op == qau_pkg::OP_MAT) ? (r == 2) : 1'b1;
      res_next[r].status = st ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
    end
  end

  // stage 3: hold rows, release one at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v   <= s2_v;
      s3_res <= res_next;
      s3_cnt <= cnt_next;
      s3_row <= '0;
    end else if (s3_fire) begin
      s3_row <= s3_row + 1'b1;
    end
  end

  assign cur = s3_res[s3_row];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      if (norm_done && (!out_v || pop)) begin
        out_v   <= 1'b1;
        res_out <= norm_res;
      end else if (s3_fire) begin
        out_v   <= 1'b1;
        res_out <= cur;
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

endmodule

@@ design/quaternion_arith_unit.sv @@
// Quaternion arithmetic unit, signed Q4.28 operands and results.
// Input side is a queue: an item (op, A, B, scale_factor) enters when push
// is high and full is low. Result side is a queue too: the oldest result sits
// on c0..c3, row, last, status while empty is low and leaves on pop.
// Ops: multiply, add, scale, normalize, rotation matrix (three rows, last
// marks row 2). Unknown opcodes are dropped with no result.
// A four-entry request queue feeds a three-stage datapath (products, sums,
// round/saturate) and an output register. Multiply, add and scale take one
// item per cycle while the output is popped. The matrix op holds its row
// stage until its three rows leave, one row per cycle while pop keeps up.
// Normalize runs in a separate sequencer once the pipeline and the output
// register are empty: squares and sum, then a bit-serial root, then four
// bit-serial divisions (skipped when the norm is zero).
// When pop stays low results hold and back pressure reaches full once the
// queue fills. Reset (rst, synchronous) empties the queue and pipeline.
module quaternion_arith_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [2:0]                        op,
  input  logic signed [qau_pkg::DataWidth-1:0] a_s,
  input  logic signed [qau_pkg::DataWidth-1:0] a_x,
  input  logic signed [qau_pkg::DataWidth-1:0] a_y,
  input  logic signed [qau_pkg::DataWidth-1:0] a_z,
  input  logic signed [qau_pkg::DataWidth-1:0] b_s,
  input  logic signed [qau_pkg::DataWidth-1:0] b_x,
  input  logic signed [qau_pkg::DataWidth-1:0] b_y,
  input  logic signed [qau_pkg::DataWidth-1:0] b_z,
  input  logic signed [qau_pkg::DataWidth-1:0] scale_factor,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [qau_pkg::DataWidth-1:0] c0,
  output logic signed [qau_pkg::DataWidth-1:0] c1,
  output logic signed [qau_pkg::DataWidth-1:0] c2,
  output logic signed [qau_pkg::DataWidth-1:0] c3,
  output logic [1:0]                        row,
  output logic                              last,
  output logic [1:0]                        status
);

  qau_pkg::req_t req;
  qau_pkg::req_t q_data;
  qau_pkg::res_t res;
  logic          q_valid;
  logic          q_take;

  assign req.op = qau_pkg::op_t'(op);
  assign req.a_s = a_s;
  assign req.a_x = a_x;
  assign req.a_y = a_y;
  assign req.a_z = a_z;
  assign req.b_s = b_s;
  assign req.b_x = b_x;
  assign req.b_y = b_y;
  assign req.b_z = b_z;
  assign req.k   = scale_factor;

  qau_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .req_in (req),
    .q_valid(q_valid),
    .q_data (q_data),
    .q_take (q_take)
  );

  qau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_data (q_data),
    .q_take (q_take),
    .empty  (empty),
    .pop    (pop),
    .res_out(res)
  );

  assign c0     = res.c0;
  assign c1     = res.c1;
  assign c2     = res.c2;
  assign c3     = res.c3;
  assign row    = res.row;
  assign last   = res.last;
  assign status = res.status;

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DataWidth = qau_pkg::DataWidth;
  localparam int FracBits  = qau_pkg::FracBits;

  typedef qau_pkg::req_t    req_t;
  typedef qau_pkg::res_t    res_t;
  typedef qau_pkg::op_t     op_t;
  typedef qau_pkg::status_t status_t;

  typedef logic signed [255:0] acc_t;

  typedef struct {
    req_t rq;
    bit   known;
    res_t want;
  } job_t;

  localparam int  CycleLimit = 2000000;
  localparam int  HoldCycles = 90;
  localparam int  RandItems  = 250;
  localparam logic signed [DataWidth-1:0] WMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] WMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] WOne = 1 <<< FracBits;
  localparam logic signed [DataWidth-1:0] WTwo = 2 <<< FracBits;

  logic clk, rst, push, full, empty, pop, last;
  logic [2:0] op;
  logic [1:0] row, status;
  logic signed [DataWidth-1:0] a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z, scale_factor;
  logic signed [DataWidth-1:0] c0, c1, c2, c3;

  job_t jobs[$];
  res_t rows_due[$];
  int   errors, rows_seen, cycles;
  int   op_count[8];

  quaternion_arith_unit dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // abort on a stuck run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic req_t mk(op_t o, logic signed [DataWidth-1:0] as, ax, ay, az,
                              bs, bx, by, bz, kf);
    req_t r;
    r.op = o; r.a_s = as; r.a_x = ax; r.a_y = ay; r.a_z = az;
    r.b_s = bs; r.b_x = bx; r.b_y = by; r.b_z = bz; r.k = kf;
    return r;
  endfunction

  function automatic res_t mkres(logic signed [DataWidth-1:0] x0, x1, x2, x3,
                                 status_t st);
    res_t e;
    e.c0 = x0; e.c1 = x1; e.c2 = x2; e.c3 = x3;
    e.row = 0; e.last = 1; e.status = st;
    return e;
  endfunction

  // round to FracBits when asked, then clamp to the word range
  function automatic logic signed [DataWidth-1:0] clamp(acc_t v, bit rnd, inout bit sat);
    acc_t t, hi, lo;
    hi = (acc_t'(1) <<< (DataWidth - 1)) - 1;
    lo = -(acc_t'(1) <<< (DataWidth - 1));
    t = rnd ? ((v + (acc_t'(1) <<< (FracBits - 1))) >>> FracBits) : v;
    if (t > hi) begin
      sat = 1; t = hi;
    end else if (t < lo) begin
      sat = 1; t = lo;
    end
    return t[DataWidth-1:0];
  endfunction

  function automatic res_t pack_row(acc_t v[4], bit rnd, logic [1:0] r, bit lst, bit zero);
    res_t e;
    bit sat;
    sat = 0;
    e.c0 = clamp(v[0], rnd, sat);
    e.c1 = clamp(v[1], rnd, sat);
    e.c2 = clamp(v[2], rnd, sat);
    e.c3 = clamp(v[3], rnd, sat);
    e.row = r;
    e.last = lst;
    e.status = zero ? qau_pkg::ST_ZERO : (sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK);
    return e;
  endfunction

  function automatic acc_t floor_root(acc_t n);
    acc_t rt, t;
    rt = 0;
    for (int b = 66; b >= 0; b--) begin
      t = rt | (acc_t'(1) <<< b);
      if (t * t <= n) rt = t;
    end
    return rt;
  endfunction

  // compute the result rows one request produces
  task automatic predict_rows(req_t r);
    acc_t a[4], b[4], kf, c[4], one, n2, rt, d, mag, q;
    acc_t xx, yy, zz, xy, xz, yz, sx, sy, sz;
    a[0] = $signed(r.a_s); a[1] = $signed(r.a_x);
    a[2] = $signed(r.a_y); a[3] = $signed(r.a_z);
    b[0] = $signed(r.b_s); b[1] = $signed(r.b_x);
    b[2] = $signed(r.b_y); b[3] = $signed(r.b_z);
    kf = $signed(r.k);
    case (r.op)
      qau_pkg::OP_MUL: begin
        c[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        c[1] = a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2];
        c[2] = a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3];
        c[3] = a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1];
        rows_due.push_back(pack_row(c, 1, 0, 1, 0));
      end
      qau_pkg::OP_ADD: begin
        for (int i = 0; i < 4; i++) c[i] = a[i] + b[i];
        rows_due.push_back(pack_row(c, 0, 0, 1, 0));
      end
      qau_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) c[i] = a[i] * kf;
        rows_due.push_back(pack_row(c, 1, 0, 1, 0));
      end
      qau_pkg::OP_NORM: begin
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += a[i] * a[i];
        if (n2 == 0) begin
          c[0] = acc_t'(1) <<< FracBits; c[1] = 0; c[2] = 0; c[3] = 0;
          rows_due.push_back(pack_row(c, 0, 0, 1, 1));
        end else begin
          rt = floor_root(n2 <<< (2 * FracBits));
          d = rt <<< 1;
          for (int i = 0; i < 4; i++) begin
            mag = a[i] < 0 ? -a[i] : a[i];
            q = ((mag <<< (2 * FracBits + 1)) + rt) / d;
            c[i] = a[i] < 0 ? -q : q;
          end
          rows_due.push_back(pack_row(c, 0, 0, 1, 0));
        end
      end
      qau_pkg::OP_MAT: begin
        one = acc_t'(1) <<< (2 * FracBits);
        xx = 2*a[1]*a[1]; yy = 2*a[2]*a[2]; zz = 2*a[3]*a[3];
        xy = 2*a[1]*a[2]; xz = 2*a[1]*a[3]; yz = 2*a[2]*a[3];
        sx = 2*a[0]*a[1]; sy = 2*a[0]*a[2]; sz = 2*a[0]*a[3];
        c[3] = 0;
        c[0] = one - yy - zz; c[1] = xy - sz; c[2] = xz + sy;
        rows_due.push_back(pack_row(c, 1, 0, 0, 0));
        c[0] = xy + sz; c[1] = one - xx - zz; c[2] = yz - sx;
        rows_due.push_back(pack_row(c, 1, 1, 0, 0));
        c[0] = xz - sy; c[1] = yz + sx; c[2] = one - xx - yy;
        rows_due.push_back(pack_row(c, 1, 2, 1, 0));
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [DataWidth-1:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      4: begin
        case ($urandom_range(0, 4))
          0: return WMax;
          1: return WMin;
          2: return WOne;
          3: return -1;
          default: return -WOne;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic req_t pick_req();
    req_t r;
    int   p;
    p = $urandom_range(0, 99);
    if (p < 24) r.op = qau_pkg::OP_MUL;
    else if (p < 44) r.op = qau_pkg::OP_ADD;
    else if (p < 64) r.op = qau_pkg::OP_SCALE;
    else if (p < 70) r.op = qau_pkg::OP_NORM;
    else if (p < 96) r.op = qau_pkg::OP_MAT;
    else r.op = op_t'(qau_pkg::OP_MAT + $urandom_range(1, 3));
    r.a_s = pick_word(); r.a_x = pick_word(); r.a_y = pick_word(); r.a_z = pick_word();
    r.b_s = pick_word(); r.b_x = pick_word(); r.b_y = pick_word(); r.b_z = pick_word();
    r.k = pick_word();
    // pure vector times quaternion now and then
    if ($urandom_range(0, 7) == 0) r.a_s = 0;
    return r;
  endfunction

  task automatic add_job(req_t r, bit known, res_t e);
    job_t j;
    j.rq = r; j.known = known; j.want = e;
    jobs.push_back(j);
  endtask

  // sender: offer each request after a random gap, or none in bursts
  task automatic drive_requests();
    int gap;
    foreach (jobs[n]) begin
      if (n == 150) begin
        // stop offering and drain every outstanding result
        @(negedge clk);
        push = 0;
        while (rows_due.size() != 0) @(negedge clk);
      end
      gap = (n % 60 < 12) ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        push = 0;
      end
      @(negedge clk);
      op = jobs[n].rq.op;
      a_s = jobs[n].rq.a_s; a_x = jobs[n].rq.a_x;
      a_y = jobs[n].rq.a_y; a_z = jobs[n].rq.a_z;
      b_s = jobs[n].rq.b_s; b_x = jobs[n].rq.b_x;
      b_y = jobs[n].rq.b_y; b_z = jobs[n].rq.b_z;
      scale_factor = jobs[n].rq.k;
      push = 1;
      do @(posedge clk); while (full);
      op_count[jobs[n].rq.op]++;
      if (jobs[n].known) rows_due.push_back(jobs[n].want);
      else predict_rows(jobs[n].rq);
    end
    @(negedge clk);
    push = 0;
  endtask

  // receiver: pop with random stalls, one long hold to back up the queue
  initial begin
    int  w;
    bit  held;
    res_t e;
    pop = 0;
    held = 0;
    wait (rst === 1'b0);
    forever begin
      w = ((rows_seen % 50) < 10) ? 0 : $urandom_range(0, 9);
      if (rows_seen == 40 && !held) begin
        w = HoldCycles;
        held = 1;
      end
      repeat (w) begin
        @(negedge clk);
        pop = 0;
      end
      @(negedge clk);
      pop = 1;
      do @(posedge clk); while (empty);
      rows_seen++;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected result c0=%h c1=%h c2=%h c3=%h row=%0d last=%0d st=%0d",
                 $time, c0, c1, c2, c3, row, last, status);
        errors++;
      end else begin
        e = rows_due.pop_front();
        if (c0 !== e.c0 || c1 !== e.c1 || c2 !== e.c2 || c3 !== e.c3 ||
            row !== e.row || last !== e.last || status !== e.status) begin
          $display("%0t: mismatch exp c=%h %h %h %h row=%0d last=%0d st=%0d", $time,
                   e.c0, e.c1, e.c2, e.c3, e.row, e.last, e.status);
          $display("%0t:          got c=%h %h %h %h row=%0d last=%0d st=%0d", $time,
                   c0, c1, c2, c3, row, last, status);
          errors++;
        end
      end
    end
  end

  initial begin
    res_t none;
    none = mkres(0, 0, 0, 0, qau_pkg::ST_OK);
    rst = 1; push = 0; op = qau_pkg::OP_MUL;
    a_s = 0; a_x = 0; a_y = 0; a_z = 0; b_s = 0; b_x = 0; b_y = 0; b_z = 0;
    scale_factor = 0;

    // directed rows: identities, extremes, zero norm, unknown codes
    add_job(mk(qau_pkg::OP_MUL, WOne, 0, 0, 0, WOne, 0, 0, 0, 0), 1,
            mkres(WOne, 0, 0, 0, qau_pkg::ST_OK));
    add_job(mk(qau_pkg::OP_ADD, WMax, WMax, WMax, WMax, WMax, WMax, WMax, WMax, 0), 1,
            mkres(WMax, WMax, WMax, WMax, qau_pkg::ST_SAT));
    add_job(mk(qau_pkg::OP_ADD, WMin, WMin, WMin, WMin, WMin, WMin, WMin, WMin, 0), 1,
            mkres(WMin, WMin, WMin, WMin, qau_pkg::ST_SAT));
    add_job(mk(qau_pkg::OP_ADD, WMax, WMin, 0, -1, 0, WMax, -1, 1, 0), 0, none);
    add_job(mk(qau_pkg::OP_SCALE, WOne, 0, 0, 0, 0, 0, 0, 0, WOne), 1,
            mkres(WOne, 0, 0, 0, qau_pkg::ST_OK));
    add_job(mk(qau_pkg::OP_SCALE, WMin, WMax, -1, WOne, 0, 0, 0, 0, WMin), 0, none);
    add_job(mk(qau_pkg::OP_NORM, 0, 0, 0, 0, WMax, WMin, 1, 1, WMax), 1,
            mkres(WOne, 0, 0, 0, qau_pkg::ST_ZERO));
    add_job(mk(qau_pkg::OP_NORM, WTwo, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_job(mk(qau_pkg::OP_NORM, WMin, WMin, WMin, WMin, 0, 0, 0, 0, 0), 0, none);
    add_job(mk(qau_pkg::OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0, 0), 0, none);
    add_job(mk(qau_pkg::OP_MAT, WOne, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_job(mk(qau_pkg::OP_MAT, WMax, WMax, WMax, WMax, 0, 0, 0, 0, 0), 0, none);
    add_job(mk(qau_pkg::OP_MAT, WMin, WMax, WMin, -1, 0, 0, 0, 0, 0), 0, none);
    add_job(mk(qau_pkg::OP_MUL, WMin, WMin, WMin, WMin, WMin, WMin, WMin, WMin, 0), 0,
            none);
    add_job(mk(qau_pkg::OP_MUL, WMax, WMin, WMax, WMin, WMin, WMax, WMin, WMax, 0), 0,
            none);
    add_job(mk(qau_pkg::OP_MUL, 0, WOne, -WOne, WTwo, WOne, WOne, 0, -1, 0), 0, none);
    for (int u = 1; u <= 3; u++)
      add_job(mk(op_t'(qau_pkg::OP_MAT + u), WMax, 1, 2, 3, 4, 5, 6, 7, 8), 0, none);
    add_job(mk(qau_pkg::OP_ADD, -1, -1, -1, -1, 1, 1, 1, 1, 0), 1,
            mkres(0, 0, 0, 0, qau_pkg::ST_OK));
    for (int n = 0; n < RandItems; n++) add_job(pick_req(), 0, none);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    drive_requests();
    while (rows_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests: mul %0d add %0d scale %0d norm %0d matrix %0d other %0d",
             jobs.size(), op_count[qau_pkg::OP_MUL], op_count[qau_pkg::OP_ADD],
             op_count[qau_pkg::OP_SCALE], op_count[qau_pkg::OP_NORM],
             op_count[qau_pkg::OP_MAT], op_count[5] + op_count[6] + op_count[7]);
    $display("Checked %0d result rows, %0d errors, %0d cycles", rows_seen, errors, cycles);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
